>>> rtl/stdpw_pkg.sv
// ----------------------------------------------------------------------------
// stdpw_pkg
// Shared constants and table builders for the STDP synapse update unit.
// ----------------------------------------------------------------------------
package stdpw_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MAX_COND  = 3'd0;
  localparam logic [2:0] REG_HALF      = 3'd1;
  localparam logic [2:0] REG_SLOPE     = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE = 3'd3;
  localparam logic [2:0] REG_INIT_RAW  = 3'd4;

  // Curve rewritten as (m*exp(-(Z0 + B*m)))^10; Z0 in Q.24, B in Q0.32
  localparam logic [31:0] NEG_Z0 = 32'd19323115;
  localparam logic [31:0] NEG_B  = 32'd571768078;
  localparam logic [31:0] POS_Z0 = 32'd25773153;
  localparam logic [31:0] POS_B  = 32'd385028502;

  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [63:0] ONE32 = 64'h1_0000_0000;

  // Restoring divide, used only while building the tables
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-h) in Q0.32 by Taylor series, h in Q0.32 and at most one half
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] h);
    logic [63:0] sum;
    logic [63:0] t;
    sum = ONE32;
    t   = ONE32;
    for (int n = 1; n <= 24; n++) begin
      t = udiv64((t * h) >> 32, 64'(n));
      if (n[0]) sum = sum - t;
      else      sum = sum + t;
    end
    return sum;
  endfunction

  // exp(-z) over z in [0,16], entry k, Q0.30
  function automatic logic [30:0] exp_entry(input int k, input int depth);
    logic [63:0] r;
    logic [63:0] cur;
    logic [63:0] res;
    r   = exp_neg_q32(udiv64(64'd1 << 36, 64'(depth)));
    cur = ONE32;
    for (int j = 0; j < k; j++) begin
      cur = (cur * r + (64'd1 << 31)) >> 32;
    end
    res = (cur + 64'd2) >> 2;
    return res[30:0];
  endfunction

  // tanh over [0,4], entry k, Q0.30
  function automatic logic [30:0] tanh_entry(input int k, input int depth);
    logic [63:0] s;
    logic [63:0] cur;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] res;
    s   = exp_neg_q32(udiv64(64'd1 << 35, 64'(depth)));
    cur = ONE32;
    for (int j = 0; j < k; j++) begin
      cur = (cur * s + (64'd1 << 31)) >> 32;
    end
    num = (ONE32 - cur) << 30;
    den = ONE32 + cur;
    res = udiv64(num + (den >> 1), den);
    return res[30:0];
  endfunction

endpackage

>>> rtl/stdpw_lut.sv
// ----------------------------------------------------------------------------
// stdpw_lut
// Constant interpolation table: returns the entries at idx and idx+1.
// ----------------------------------------------------------------------------
module stdpw_lut import stdpw_pkg::*; #(
  parameter int DEPTH   = 256,
  parameter bit IS_TANH = 1'b0,
  localparam int IW     = $clog2(DEPTH + 1)
) (
  input  logic [IW-1:0] idx,
  output logic [30:0]   lo_val,
  output logic [30:0]   hi_val
);

  logic [30:0]   rom [0:DEPTH];
  logic [IW-1:0] idx_p1;

  for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
    localparam logic [30:0] ENTRY = IS_TANH ? tanh_entry(k, DEPTH) : exp_entry(k, DEPTH);
    assign rom[k] = ENTRY;
  end

  assign idx_p1 = idx + 1'b1;
  assign lo_val = rom[idx];
  assign hi_val = rom[idx_p1];

endmodule

>>> rtl/stdp_synapse_weight_update_unit.sv
// ----------------------------------------------------------------------------
// stdp_synapse_weight_update_unit
// STDP weight update with sigmoid conductance readout for a single synapse.
// ----------------------------------------------------------------------------
// Usage
//   Input items carry the pre/post spike-start flags and last spike times
//   (unsigned Q24.8 ms). When either flag is set and both times are nonzero
//   the STDP curve is evaluated and amplitude*f is added to the raw strength
//   with saturation. Every item returns one result: change flag, applied
//   delta, raw strength and the sigmoid conductance.
//   One shared 33x33 multiplier is stepped by the sequencer, so one item is
//   carried from acceptance to out_valid before the next is taken; items with
//   no update or a saturated tanh skip steps. in_ready is high only while idle.
//   The result sits in an output register; the sequencer holds in its last
//   step while a previous result is still waiting to be taken.
//   Configuration writes (cfg_valid/cfg_ready, cfg_ready always high) must be
//   made while idle, unchecked by the block; writing initial_raw_strength
//   also loads raw strength. Reset (synchronous, active low) restores register
//   defaults, clears the change flag and clears raw strength to zero.
// ----------------------------------------------------------------------------
module stdp_synapse_weight_update_unit import stdpw_pkg::*; #(
  parameter int EXP_TABLE_DEPTH    = 256,
  parameter int TANH_TABLE_DEPTH   = 256,
  parameter int TIME_FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_pre_spike_start,
  input  logic               in_post_spike_start,
  input  logic [31:0]        in_pre_spike_time,
  input  logic [31:0]        in_post_spike_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_change_flag,
  output logic signed [31:0] out_weight_delta,
  output logic signed [31:0] out_raw_strength_out,
  output logic [31:0]        out_conductance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int EIW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int TIW = $clog2(TANH_TABLE_DEPTH + 1);
  localparam int MSH = 24 - TIME_FRACTION_BITS;
  localparam logic [32:0] WIN_NEG = 33'(40) << TIME_FRACTION_BITS;
  localparam logic [32:0] WIN_POS = 33'(80) << TIME_FRACTION_BITS;
  localparam logic signed [33:0] X_OFS = 34'(5) << TIME_FRACTION_BITS;

  // Sequencer steps; M* steps issue a product, the next step consumes it
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CHK  = 5'd1;
  localparam logic [4:0] S_MZB  = 5'd2;
  localparam logic [4:0] S_Z    = 5'd3;
  localparam logic [4:0] S_MEP  = 5'd4;
  localparam logic [4:0] S_ETAB = 5'd5;
  localparam logic [4:0] S_MIE  = 5'd6;
  localparam logic [4:0] S_E    = 5'd7;
  localparam logic [4:0] S_MV   = 5'd8;
  localparam logic [4:0] S_V    = 5'd9;
  localparam logic [4:0] S_MP2  = 5'd10;
  localparam logic [4:0] S_P2   = 5'd11;
  localparam logic [4:0] S_MP4  = 5'd12;
  localparam logic [4:0] S_P4   = 5'd13;
  localparam logic [4:0] S_MP8  = 5'd14;
  localparam logic [4:0] S_P8   = 5'd15;
  localparam logic [4:0] S_MP10 = 5'd16;
  localparam logic [4:0] S_P10  = 5'd17;
  localparam logic [4:0] S_MD   = 5'd18;
  localparam logic [4:0] S_D    = 5'd19;
  localparam logic [4:0] S_SUM  = 5'd20;
  localparam logic [4:0] S_DIFF = 5'd21;
  localparam logic [4:0] S_MPR  = 5'd22;
  localparam logic [4:0] S_PR   = 5'd23;
  localparam logic [4:0] S_MTP  = 5'd24;
  localparam logic [4:0] S_TTAB = 5'd25;
  localparam logic [4:0] S_MIT  = 5'd26;
  localparam logic [4:0] S_T    = 5'd27;
  localparam logic [4:0] S_ONEP = 5'd28;
  localparam logic [4:0] S_MG   = 5'd29;
  localparam logic [4:0] S_G    = 5'd30;

  function automatic logic [30:0] rnd30(input logic [65:0] p);
    logic [65:0] s;
    s = (p + (66'd1 << 29)) >> 30;
    return s[30:0];
  endfunction

  // Control and configuration
  logic [4:0]         state_r;
  logic               out_valid_r;
  logic [31:0]        gmax_r;
  logic signed [31:0] half_r;
  logic signed [31:0] slope_r;
  logic signed [31:0] amp_r;
  logic signed [31:0] raw_r;
  logic               changed_r;

  // Datapath
  logic signed [33:0] x_r;
  logic               upd_r;
  logic               neg_r;
  logic [30:0]        m_r;
  logic [29:0]        z_r;
  logic [27:0]        frac_r;
  logic [30:0]        ta_r;
  logic [30:0]        diff_r;
  logic [30:0]        e_r;
  logic [30:0]        v_r;
  logic [30:0]        p2_r;
  logic [24:0]        af_r;
  logic signed [31:0] delta_r;
  logic [32:0]        ad_r;
  logic               gneg_r;
  logic [25:0]        u_r;
  logic [31:0]        onep_r;
  logic [65:0]        p_r;
  logic               out_change_r;
  logic signed [31:0] out_delta_r;
  logic signed [31:0] out_raw_r;
  logic [31:0]        out_cond_r;

  // Shared multiplier operands
  logic [32:0] mul_a;
  logic [32:0] mul_b;

  logic [30:0] exp_lo, exp_hi, tanh_lo, tanh_hi;
  logic        in_acc, out_free;

  // Helpers for the individual steps
  logic [33:0] x_abs;
  logic [32:0] ax;
  logic        win_out;
  logic [65:0] z_full;
  logic [65:0] v_full;
  logic [31:0] p10_w;
  logic [31:0] mag_w;
  logic [65:0] dm_full;
  logic [30:0] dmag;
  logic signed [31:0] delta_w;
  logic signed [32:0] sum_w;
  logic signed [32:0] d_w;
  logic [31:0] amp_abs, slope_abs;
  logic [31:0] th_w;
  logic [65:0] rnd_e, rnd_t, g_full;

  stdpw_lut #(.DEPTH(EXP_TABLE_DEPTH), .IS_TANH(1'b0)) u_exp_lut (
    .idx    (p_r[28 +: EIW]),
    .lo_val (exp_lo),
    .hi_val (exp_hi)
  );

  stdpw_lut #(.DEPTH(TANH_TABLE_DEPTH), .IS_TANH(1'b1)) u_tanh_lut (
    .idx    (p_r[26 +: TIW]),
    .lo_val (tanh_lo),
    .hi_val (tanh_hi)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_change_flag      = out_change_r;
  assign out_weight_delta     = out_delta_r;
  assign out_raw_strength_out = out_raw_r;
  assign out_conductance      = out_cond_r;

  // Shifted time difference magnitude and window test
  assign x_abs   = x_r[33] ? 34'(-x_r) : 34'(x_r);
  assign ax      = x_abs[32:0];
  assign win_out = x_r[33] ? (ax > WIN_NEG) : (ax > WIN_POS);

  assign z_full  = {34'd0, (neg_r ? NEG_Z0 : POS_Z0)} + ((p_r + (66'd1 << 31)) >> 32);
  assign rnd_e   = (p_r + (66'd1 << 27)) >> 28;
  assign v_full  = (p_r + (66'd1 << 23)) >> 24;
  assign p10_w   = {1'b0, rnd30(p_r)} + 32'd32;
  assign mag_w   = p10_w >> 6;
  assign dm_full = (p_r + (66'd1 << 23)) >> 24;
  assign dmag    = (dm_full > 66'h7FFF_FFFF) ? 31'h7FFF_FFFF : dm_full[30:0];
  assign delta_w = (neg_r ^ amp_r[31]) ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
  assign sum_w   = {raw_r[31], raw_r} + {delta_r[31], delta_r};
  assign d_w     = {raw_r[31], raw_r} - {half_r[31], half_r};
  assign amp_abs   = amp_r[31]   ? 32'(-amp_r)   : 32'(amp_r);
  assign slope_abs = slope_r[31] ? 32'(-slope_r) : 32'(slope_r);
  assign rnd_t   = (p_r + (66'd1 << 25)) >> 26;
  assign th_w    = {1'b0, ta_r} + rnd_t[31:0];
  assign g_full  = (p_r + (66'd1 << 30)) >> 31;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MZB: begin
        mul_a = {2'b0, m_r};
        mul_b = {1'b0, (neg_r ? NEG_B : POS_B)};
      end
      S_MEP: begin
        mul_a = {3'b0, z_r};
        mul_b = 33'(EXP_TABLE_DEPTH);
      end
      S_MIE, S_MIT: begin
        mul_a = {2'b0, diff_r};
        mul_b = {5'b0, frac_r};
      end
      S_MV: begin
        mul_a = {2'b0, m_r};
        mul_b = {2'b0, e_r};
      end
      S_MP2: begin
        mul_a = {2'b0, v_r};
        mul_b = {2'b0, v_r};
      end
      S_MP4: begin
        mul_a = {2'b0, p2_r};
        mul_b = {2'b0, p2_r};
      end
      S_MP8: begin
        mul_a = {2'b0, v_r};
        mul_b = {2'b0, v_r};
      end
      S_MP10: begin
        mul_a = {2'b0, v_r};
        mul_b = {2'b0, p2_r};
      end
      S_MD: begin
        mul_a = {1'b0, amp_abs};
        mul_b = {8'b0, af_r};
      end
      S_MPR: begin
        mul_a = ad_r;
        mul_b = {1'b0, slope_abs};
      end
      S_MTP: begin
        mul_a = {7'b0, u_r};
        mul_b = 33'(TANH_TABLE_DEPTH);
      end
      // hold the operands while a finished result waits
      S_MG, S_G: begin
        mul_a = {1'b0, gmax_r};
        mul_b = {1'b0, onep_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer, configuration and synapse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gmax_r      <= 32'd65536;
      half_r      <= '0;
      slope_r     <= 32'sd16777216;
      amp_r       <= 32'sd16777216;
      raw_r       <= '0;
      changed_r   <= 1'b0;
    end else begin
      // drop the result once taken, unless the next one replaces it now
      if (out_valid_r && out_ready && state_r != S_G) out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_COND:  gmax_r  <= cfg_data;
          REG_HALF:      half_r  <= $signed(cfg_data);
          REG_SLOPE:     slope_r <= $signed(cfg_data);
          REG_AMPLITUDE: amp_r   <= $signed(cfg_data);
          REG_INIT_RAW:  raw_r   <= $signed(cfg_data);
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: if (in_acc) state_r <= S_CHK;
        S_CHK: begin
          if (!upd_r) begin
            state_r <= S_DIFF;
          end else if (ax == 33'd0 || win_out) begin
            // zero curve: clear the flag, strength unchanged
            changed_r <= 1'b0;
            state_r   <= S_DIFF;
          end else begin
            state_r <= S_MZB;
          end
        end
        S_MZB: state_r <= S_Z;
        S_Z: begin
          // exp(-z) underflows to zero from z = 16 on
          if (z_full >= (66'd16 << 24)) begin
            changed_r <= 1'b0;
            state_r   <= S_DIFF;
          end else begin
            state_r <= S_MEP;
          end
        end
        S_MEP:  state_r <= S_ETAB;
        S_ETAB: state_r <= S_MIE;
        S_MIE:  state_r <= S_E;
        S_E:    state_r <= S_MV;
        S_MV:   state_r <= S_V;
        S_V:    state_r <= S_MP2;
        S_MP2:  state_r <= S_P2;
        S_P2:   state_r <= S_MP4;
        S_MP4:  state_r <= S_P4;
        S_P4:   state_r <= S_MP8;
        S_MP8:  state_r <= S_P8;
        S_P8:   state_r <= S_MP10;
        S_MP10: state_r <= S_P10;
        S_P10: begin
          if (mag_w == 32'd0) begin
            changed_r <= 1'b0;
            state_r   <= S_DIFF;
          end else begin
            state_r <= S_MD;
          end
        end
        S_MD: state_r <= S_D;
        S_D:  state_r <= S_SUM;
        S_SUM: begin
          // saturate the new strength to the signed 32-bit range
          if (sum_w[32] != sum_w[31]) raw_r <= sum_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          else                        raw_r <= sum_w[31:0];
          changed_r <= 1'b1;
          state_r   <= S_DIFF;
        end
        S_DIFF: state_r <= S_MPR;
        S_MPR:  state_r <= S_PR;
        S_PR: begin
          if (p_r >= (66'd4 << 48)) state_r <= S_ONEP;
          else                      state_r <= S_MTP;
        end
        S_MTP:  state_r <= S_TTAB;
        S_TTAB: state_r <= S_MIT;
        S_MIT:  state_r <= S_T;
        S_T:    state_r <= S_ONEP;
        S_ONEP: state_r <= S_MG;
        S_MG:   state_r <= S_G;
        S_G: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_r     <= $signed({2'b0, in_post_spike_time}) - $signed({2'b0, in_pre_spike_time})
                     + X_OFS;
          upd_r   <= (in_pre_spike_start || in_post_spike_start) &&
                     (in_pre_spike_time != 32'd0) && (in_post_spike_time != 32'd0);
          delta_r <= '0;
        end
      end
      S_CHK: begin
        neg_r <= x_r[33];
        m_r   <= 31'(ax << MSH);
      end
      S_Z: z_r <= z_full[29:0];
      S_ETAB: begin
        frac_r <= p_r[27:0];
        ta_r   <= exp_lo;
        diff_r <= exp_lo - exp_hi;
      end
      S_E:  e_r  <= ta_r - rnd_e[30:0];
      S_V:  v_r  <= (v_full > {35'd0, ONE30}) ? ONE30 : v_full[30:0];
      S_P2: p2_r <= rnd30(p_r);
      S_P4: v_r  <= rnd30(p_r);
      S_P8: v_r  <= rnd30(p_r);
      S_P10: af_r <= mag_w[24:0];
      S_D:  delta_r <= delta_w;
      S_DIFF: begin
        ad_r   <= d_w[32] ? 33'(-d_w) : 33'(d_w);
        gneg_r <= d_w[32] ^ slope_r[31];
      end
      S_PR: begin
        // tanh saturates to one from an argument of four on
        e_r <= ONE30;
        u_r <= p_r[49:24];
      end
      S_TTAB: begin
        frac_r <= {2'b0, p_r[25:0]};
        ta_r   <= tanh_lo;
        diff_r <= tanh_hi - tanh_lo;
      end
      S_T:    e_r <= (th_w > {1'b0, ONE30}) ? ONE30 : th_w[30:0];
      S_ONEP: onep_r <= gneg_r ? ({1'b0, ONE30} - {1'b0, e_r}) : ({1'b0, ONE30} + {1'b0, e_r});
      S_G: begin
        if (out_free) begin
          out_change_r <= changed_r;
          out_delta_r  <= delta_r;
          out_raw_r    <= raw_r;
          out_cond_r   <= g_full[31:0];
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/stdp_synapse_weight_update_unit_tb.sv
// ----------------------------------------------------------------------------
// stdp_synapse_weight_update_unit_tb
// Self-checking bench for the STDP weight update unit: every accepted item is
// predicted by an integer model of the curve, the table lookups and the
// sigmoid readout, and each returned result is compared field by field.
// ----------------------------------------------------------------------------
module stdp_synapse_weight_update_unit_tb;
  import stdpw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXP_DEPTH  = 256;
  localparam int TANH_DEPTH = 256;
  localparam int TFRAC      = 8;
  localparam int HOLD_OFF_LEN = 400;

  typedef struct packed {
    logic        flag;
    logic [31:0] delta;
    logic [31:0] raw;
    logic [31:0] cond;
  } synapse_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_pre_spike_start = 1'b0;
  logic               in_post_spike_start = 1'b0;
  logic [31:0]        in_pre_spike_time = '0;
  logic [31:0]        in_post_spike_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_change_flag;
  logic signed [31:0] out_weight_delta;
  logic signed [31:0] out_raw_strength_out;
  logic [31:0]        out_conductance;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  stdp_synapse_weight_update_unit uut (.*);

  // Predictor copy of the tables, registers and synapse state
  logic [31:0] exp_lut  [0:EXP_DEPTH];
  logic [31:0] tanh_lut [0:TANH_DEPTH];
  logic [63:0] gmax_q;
  longint      half_q, slope_q, amp_q, init_raw_q, raw_q;
  logic        flag_q;

  synapse_result_t pending_results[$];
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  logic hold_off_req    = 1'b0;
  logic hold_off_done   = 1'b0;
  int hold_off_count    = 0;
  int mismatches        = 0;
  int results_seen      = 0;
  int updates_predicted = 0;
  int items_sent        = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // exp(-h) by Taylor series, h and result in Q0.32
  function automatic logic [63:0] exp_series(input logic [63:0] h);
    longint      acc;
    logic [63:0] term;
    acc  = 64'sd1 <<< 32;
    term = 64'd1 << 32;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * h) >> 32) / 64'(n);
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    return 64'(acc);
  endfunction

  task automatic build_luts();
    logic [63:0] step_r, step_s, cur, num, den;
    step_r = exp_series((64'd1 << 36) / EXP_DEPTH);
    step_s = exp_series((64'd1 << 35) / TANH_DEPTH);
    cur = 64'd1 << 32;
    for (int k = 0; k <= EXP_DEPTH; k++) begin
      exp_lut[k] = 32'((cur + 64'd2) >> 2);
      cur = (cur * step_r + (64'd1 << 31)) >> 32;
    end
    cur = 64'd1 << 32;
    for (int k = 0; k <= TANH_DEPTH; k++) begin
      num = ((64'd1 << 32) - cur) << 30;
      den = (64'd1 << 32) + cur;
      tanh_lut[k] = 32'((num + den / 2) / den);
      cur = (cur * step_s + (64'd1 << 31)) >> 32;
    end
  endtask

  // exp(-z), z in Q.24, result Q0.30, interpolated
  function automatic logic [63:0] exp_interp(input logic [63:0] z);
    logic [63:0] pos, idx, frac, a, b;
    if (z >= (64'd16 << 24)) return 64'd0;
    pos  = z * EXP_DEPTH;
    idx  = pos >> 28;
    frac = pos & ((64'd1 << 28) - 1);
    a = 64'(exp_lut[idx]);
    b = 64'(exp_lut[idx + 1]);
    return a - (((a - b) * frac + (64'd1 << 27)) >> 28);
  endfunction

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Signed curve value in Q.24 for the shifted time x (Q.8)
  function automatic longint stdp_curve(input longint x);
    logic        neg;
    logic [63:0] m, z, v, p2, p4, p8, p10, mag;
    neg = x < 0;
    if (x < -(64'sd40 <<< TFRAC) || x > (64'sd80 <<< TFRAC)) return 0;
    m = (neg ? 64'(-x) : 64'(x)) << (24 - TFRAC);
    if (neg) z = 64'(NEG_Z0) + ((m * 64'(NEG_B) + (64'd1 << 31)) >> 32);
    else     z = 64'(POS_Z0) + ((m * 64'(POS_B) + (64'd1 << 31)) >> 32);
    v = (m * exp_interp(z) + (64'd1 << 23)) >> 24;
    if (v > 64'(ONE30)) v = 64'(ONE30);
    p2  = mul_q30(v, v);
    p4  = mul_q30(p2, p2);
    p8  = mul_q30(p4, p4);
    p10 = mul_q30(p8, p2);
    mag = (p10 + 64'd32) >> 6;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [31:0] sigmoid_conductance(input longint raw);
    longint      d;
    logic        neg;
    logic [63:0] ad, as_, prod, th, u, pos, idx, frac, a, b, onep;
    d    = raw - half_q;
    neg  = (d < 0) != (slope_q < 0);
    ad   = d < 0 ? 64'(-d) : 64'(d);
    as_  = slope_q < 0 ? 64'(-slope_q) : 64'(slope_q);
    prod = ad * as_;
    if (prod >= (64'd4 << 48)) begin
      th = 64'(ONE30);
    end else begin
      u    = prod >> 24;
      pos  = u * TANH_DEPTH;
      idx  = pos >> 26;
      frac = pos & ((64'd1 << 26) - 1);
      a = 64'(tanh_lut[idx]);
      b = 64'(tanh_lut[idx + 1]);
      th = a + (((b - a) * frac + (64'd1 << 25)) >> 26);
      if (th > 64'(ONE30)) th = 64'(ONE30);
    end
    onep = neg ? 64'(ONE30) - th : 64'(ONE30) + th;
    return 32'((gmax_q * onep + 64'(ONE30)) >> 31);
  endfunction

  // Advance the predicted synapse state by one item
  function automatic synapse_result_t predict_synapse(input logic ps, input logic qs,
                                                      input logic [31:0] pt,
                                                      input logic [31:0] qt);
    synapse_result_t r;
    longint      x, f, delta, sum;
    logic        neg;
    logic [63:0] af, aa, mag;
    delta = 0;
    if ((ps || qs) && pt != 0 && qt != 0) begin
      x = longint'({32'd0, qt}) - longint'({32'd0, pt}) + (64'sd5 <<< TFRAC);
      f = stdp_curve(x);
      if (f != 0) begin
        neg = (f < 0) != (amp_q < 0);
        af  = f < 0 ? 64'(-f) : 64'(f);
        aa  = amp_q < 0 ? 64'(-amp_q) : 64'(amp_q);
        mag = (aa * af + (64'd1 << 23)) >> 24;
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        delta = neg ? -longint'(mag) : longint'(mag);
        sum = raw_q + delta;
        if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
        if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
        raw_q  = sum;
        flag_q = 1'b1;
        updates_predicted++;
      end else begin
        flag_q = 1'b0;
      end
    end
    r.flag  = flag_q;
    r.delta = 32'(delta);
    r.raw   = 32'(raw_q);
    r.cond  = sigmoid_conductance(raw_q);
    return r;
  endfunction

  function automatic void predictor_reset();
    gmax_q = 64'd65536;
    half_q = 0;
    slope_q = 64'sd16777216;
    amp_q = 64'sd16777216;
    init_raw_q = 0;
    raw_q = 0;
    flag_q = 1'b0;
  endfunction

  // Offer one item, honouring the sender idle rate; leave valid high on return
  task automatic send_item(input logic ps, input logic qs,
                           input logic [31:0] pt, input logic [31:0] qt);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_pre_spike_start  <= ps;
    in_post_spike_start <= qs;
    in_pre_spike_time   <= pt;
    in_post_spike_time  <= qt;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_synapse(ps, qs, pt, qt));
    items_sent++;
  endtask

  // Hold until every result is back, then let the sequencer settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAX_COND:  gmax_q  = 64'(data);
      REG_HALF:      half_q  = longint'($signed(data));
      REG_SLOPE:     slope_q = longint'($signed(data));
      REG_AMPLITUDE: amp_q   = longint'($signed(data));
      REG_INIT_RAW: begin
        init_raw_q = longint'($signed(data));
        raw_q      = init_raw_q;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Checker: compare each taken result against the oldest prediction
  always @(posedge clk) begin
    synapse_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_change_flag !== exp_r.flag || out_weight_delta !== exp_r.delta ||
            out_raw_strength_out !== exp_r.raw || out_conductance !== exp_r.cond) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp flag %0d delta %h raw %h cond %h, got %0d %h %h %h",
                     $realtime, exp_r.flag, exp_r.delta, exp_r.raw, exp_r.cond,
                     out_change_flag, out_weight_delta, out_raw_strength_out,
                     out_conductance);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_done) begin
      out_ready <= 1'b0;
      if (hold_off_count == HOLD_OFF_LEN - 1) hold_off_done <= 1'b1;
      hold_off_count <= hold_off_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic test_reset_defaults();
    // Register defaults straight after reset
    send_item(1'b1, 1'b0, 32'd1000, 32'd3000);
    send_item(1'b0, 1'b0, 32'd1000, 32'd3000);
    wait_idle();
  endtask

  task automatic test_special_cases();
    logic [31:0] base;
    base = 32'h0010_0000;
    send_item(1'b0, 1'b0, base, base + 32'd2560);            // no spike start
    send_item(1'b1, 1'b1, 32'd0, base);                      // pre time missing
    send_item(1'b1, 1'b1, base, 32'd0);                      // post time missing
    send_item(1'b1, 1'b0, base, base - 32'd1280);            // x exactly zero
    send_item(1'b0, 1'b1, base, base - (32'd45 << TFRAC));   // window lower edge
    send_item(1'b1, 1'b1, base, base - (32'd46 << TFRAC));   // just below window
    send_item(1'b1, 1'b0, base, base + (32'd75 << TFRAC));   // window upper edge
    send_item(1'b0, 1'b1, base, base + (32'd76 << TFRAC));   // just above window
    send_item(1'b1, 1'b0, base, base + (32'd5 << TFRAC));
    send_item(1'b0, 1'b1, base, base - (32'd15 << TFRAC));
    send_item(1'b1, 1'b1, base, base + 32'd1);
    send_item(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(1'b1, 1'b1, 32'd1, 32'hFFFF_FFFF);
    send_item(1'b1, 1'b1, 32'hFFFF_FFFF, 32'd1);
    wait_idle();
    // Drive the raw strength into both saturation limits
    write_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
    write_reg(REG_INIT_RAW, 32'h7FFF_F000);
    send_item(1'b1, 1'b0, base, base + (32'd10 << TFRAC));
    send_item(1'b1, 1'b0, base, base + (32'd10 << TFRAC));
    wait_idle();
    write_reg(REG_INIT_RAW, 32'h8000_0100);
    send_item(1'b0, 1'b1, base, base - (32'd12 << TFRAC));
    send_item(1'b0, 1'b1, base, base - (32'd12 << TFRAC));
    wait_idle();
    // Saturate tanh with the steepest slopes
    write_reg(REG_SLOPE, 32'h7FFF_FFFF);
    send_item(1'b0, 1'b0, base, base);
    wait_idle();
    write_reg(REG_SLOPE, 32'h8000_0000);
    send_item(1'b0, 1'b0, base, base);
    wait_idle();
    // Unknown indexes must leave every register alone
    write_reg(3'(REG_INIT_RAW + 1), 32'hDEAD_BEEF);
    write_reg(3'(REG_INIT_RAW + 2), 32'h1234_5678);
    write_reg(3'(REG_INIT_RAW + 3), 32'hFFFF_FFFF);
    send_item(1'b1, 1'b1, base, base + (32'd3 << TFRAC));
    wait_idle();
  endtask

  // Mostly in-window pairs with random content, the rest noise
  task automatic send_random_item();
    int          kind, off;
    logic [31:0] pt, qt;
    logic [1:0]  flags;
    kind  = $urandom_range(99);
    flags = 2'($urandom_range(1, 3));
    pt    = $urandom;
    if (pt == 0) pt = 32'd1;
    if (kind < 70) begin
      off = int'($urandom_range(0, 122 << TFRAC)) - (46 << TFRAC);
      qt  = pt + 32'(off);
      if (qt == 0) qt = 32'd1;
      send_item(flags[0], flags[1], pt, qt);
    end else if (kind < 85) begin
      send_item(1'($urandom), 1'($urandom), $urandom, $urandom);
    end else if (kind < 95) begin
      qt = $urandom;
      if ($urandom_range(1)) send_item(flags[0], flags[1], 32'd0, qt);
      else                   send_item(flags[0], flags[1], qt, 32'd0);
    end else begin
      send_item(1'b0, 1'b0, pt, $urandom);
    end
  endtask

  task automatic load_settings(input int sel);
    case (sel)
      0: begin
        write_reg(REG_MAX_COND, 32'hFFFF_FFFF);
        write_reg(REG_HALF, 32'h0000_0000);
        write_reg(REG_SLOPE, 32'h0100_0000);
        write_reg(REG_AMPLITUDE, 32'h0100_0000);
        write_reg(REG_INIT_RAW, 32'h0000_0000);
      end
      1: begin
        write_reg(REG_MAX_COND, 32'h0000_0000);
        write_reg(REG_HALF, 32'h8000_0000);
        write_reg(REG_SLOPE, 32'h0000_0001);
        write_reg(REG_AMPLITUDE, 32'h8000_0000);
        write_reg(REG_INIT_RAW, 32'h7FFF_FFFF);
      end
      2: begin
        write_reg(REG_MAX_COND, 32'h0001_0000);
        write_reg(REG_HALF, 32'h7FFF_FFFF);
        write_reg(REG_SLOPE, 32'h0000_0000);
        write_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
        write_reg(REG_INIT_RAW, 32'h8000_0000);
      end
      default: begin
        write_reg(REG_MAX_COND, $urandom);
        write_reg(REG_HALF, 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000));
        write_reg(REG_SLOPE, 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000));
        write_reg(REG_AMPLITUDE, 32'($signed($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000));
        write_reg(REG_INIT_RAW, $urandom);
      end
    endcase
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int count, input int sel);
    load_settings(sel);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // Pause mid-phase until the pipe is empty once
      if (i == count / 2) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_random_item();
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    load_settings(3);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_req       = 1'b1;
    // Keep offering items while the receiver holds off
    for (int i = 0; i < 60; i++) send_random_item();
    wait_idle();
  endtask

  initial begin
    build_luts();
    predictor_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_random_phase(0, 0, 260, 0);
    test_random_phase(76, 0, 260, 1);
    test_random_phase(0, 76, 260, 2);
    test_random_phase(28, 28, 260, 3);
    test_backpressure();
    wait_idle();
    $display("Covered %0d items (%0d curve updates), %0d results returned,",
             items_sent, updates_predicted, results_seen);
    $display("across register extremes, idle and stall mixes and a long hold-off.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/stdpw_pkg.sv
rtl/stdpw_lut.sv
rtl/stdp_synapse_weight_update_unit.sv
tb/stdp_synapse_weight_update_unit_tb.sv
